// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, checked outside reset.
`define CAHV_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("cahv assertion failed");

// Condition now implies consequence on the next edge.
`define CAHV_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("cahv assertion failed");

`endif

// ===== design/cahv_pem_pkg.sv =====
package cahv_pem_pkg;

  localparam int CoordW    = 32;
  localparam int MaskW     = 8;
  localparam int CompW     = 21;
  localparam int VecW      = 63;
  localparam int DeltaW    = 35;  // exact 2*(midpoint - center)
  localparam int ProdW     = 56;
  localparam int SumW      = 58;
  localparam int QuotW     = 32;
  localparam int FracShift = 20;
  localparam int LowW      = QuotW - FracShift;
  localparam int CfgIdxW   = 3;

  localparam logic signed [MaskW-1:0] MaskVisible = 8'sd2;

  typedef enum logic [CfgIdxW-1:0] {
    RegCenterX = 3'd0,
    RegCenterY = 3'd1,
    RegCenterZ = 3'd2,
    RegAxis    = 3'd3,
    RegHoriz   = 3'd4,
    RegVert    = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StatusValid  = 2'd0,
    StatusMasked = 2'd1,
    StatusBad    = 2'd2
  } status_e;

  typedef logic [SumW-1:0] mag_t;

  // Classified request handed from the front end to the divider.
  typedef struct packed {
    mag_t mag_a;
    mag_t mag_h;
    mag_t mag_v;
    logic a_neg;
    logic a_zero;
    logic h_neg;
    logic h_zero;
    logic v_neg;
    logic v_zero;
    logic masked;
  } job_t;

endpackage

// ===== design/cahv_pem_front.sv =====
module cahv_pem_front import cahv_pem_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [CoordW-1:0]  north_first_i,
  input  logic signed [CoordW-1:0]  north_second_i,
  input  logic signed [CoordW-1:0]  east_first_i,
  input  logic signed [CoordW-1:0]  east_second_i,
  input  logic signed [CoordW-1:0]  elev_first_i,
  input  logic signed [CoordW-1:0]  elev_second_i,
  input  logic signed [MaskW-1:0]   mask_first_i,
  input  logic signed [MaskW-1:0]   mask_second_i,
  input  logic                      cfg_valid_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [VecW-1:0]           cfg_data_i,
  output logic                      job_valid_o,
  output job_t                      job_o,
  input  logic                      job_full_i
);

  logic signed [CoordW-1:0] center_q [3];
  logic [VecW-1:0]          vec_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        center_q[i] <= '0;
        vec_q[i]    <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegCenterX: center_q[0] <= cfg_data_i[CoordW-1:0];
        RegCenterY: center_q[1] <= cfg_data_i[CoordW-1:0];
        RegCenterZ: center_q[2] <= cfg_data_i[CoordW-1:0];
        RegAxis:    vec_q[0]    <= cfg_data_i;
        RegHoriz:   vec_q[1]    <= cfg_data_i;
        RegVert:    vec_q[2]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [3:0] vld_q;
  logic [3:0] msk_q;
  logic       adv;

  assign adv        = !vld_q[3] || !job_full_i;
  assign in_stall_o = !adv;

  logic signed [DeltaW-1:0] delta_d [3];
  logic signed [DeltaW-1:0] delta_q [3];
  logic signed [ProdW-1:0]  prod_d [9];
  logic signed [ProdW-1:0]  prod_q [9];
  logic signed [SumW-1:0]   sum_d [3];
  logic signed [SumW-1:0]   sum_q [3];
  job_t                     job_d, job_q;
  logic                     masked_d;

  // Deltas are kept at twice scale so the midpoint halving stays exact.
  always_comb begin
    masked_d   = (mask_first_i != MaskVisible) || (mask_second_i != MaskVisible);
    delta_d[0] = DeltaW'(north_first_i) + DeltaW'(north_second_i)
               - (DeltaW'(center_q[0]) <<< 1);
    delta_d[1] = DeltaW'(east_first_i) + DeltaW'(east_second_i)
               - (DeltaW'(center_q[1]) <<< 1);
    delta_d[2] = -(DeltaW'(elev_first_i) + DeltaW'(elev_second_i))
               - (DeltaW'(center_q[2]) <<< 1);
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[j*3+k] = ProdW'(signed'(vec_q[j][CompW*k +: CompW])) * ProdW'(delta_q[k]);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum_d[j] = SumW'(prod_q[j*3]) + SumW'(prod_q[j*3+1]) + SumW'(prod_q[j*3+2]);
    end
  end

  always_comb begin
    job_d.mag_a  = sum_q[0][SumW-1] ? mag_t'(-sum_q[0]) : mag_t'(sum_q[0]);
    job_d.mag_h  = sum_q[1][SumW-1] ? mag_t'(-sum_q[1]) : mag_t'(sum_q[1]);
    job_d.mag_v  = sum_q[2][SumW-1] ? mag_t'(-sum_q[2]) : mag_t'(sum_q[2]);
    job_d.a_neg  = sum_q[0][SumW-1];
    job_d.a_zero = (sum_q[0] == '0);
    job_d.h_neg  = sum_q[1][SumW-1];
    job_d.h_zero = (sum_q[1] == '0);
    job_d.v_neg  = sum_q[2][SumW-1];
    job_d.v_zero = (sum_q[2] == '0);
    job_d.masked = msk_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      msk_q   <= {msk_q[2:0], masked_d};
      delta_q <= delta_d;
      prod_q  <= prod_d;
      sum_q   <= sum_d;
      job_q   <= job_d;
    end
  end

  assign job_valid_o = vld_q[3];
  assign job_o       = job_q;

endmodule

// ===== design/cahv_pem_fifo.sv =====
module cahv_pem_fifo import cahv_pem_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_ready_i,
  output logic pop_valid_o,
  output job_t pop_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign pop_valid_o = (count_q != '0);
  assign push        = push_valid_i && !full_o;
  assign pop         = pop_ready_i && pop_valid_o;
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/cahv_pem_back.sv =====
module cahv_pem_back import cahv_pem_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     job_valid_i,
  input  job_t                     job_i,
  output logic                     job_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [QuotW-1:0]  image_x_o,
  output logic signed [QuotW-1:0]  image_y_o,
  output logic [1:0]               status_o
);

  localparam int Steps = QuotW;

  typedef struct packed {
    mag_t             rem;
    logic [QuotW-1:0] bits;  // dividend bits still to enter, quotient bits shifting in
  } lane_t;

  typedef struct packed {
    logic masked;
    logic a_zero;
    logic a_neg;
    logic h_neg;
    logic h_zero;
    logic v_neg;
    logic v_zero;
    logic x_ovf;
    logic y_ovf;
  } ctl_t;

  function automatic lane_t div_step(lane_t l, mag_t den);
    logic [SumW:0] trial;
    logic          ge;
    lane_t         res;
    trial    = {l.rem, l.bits[QuotW-1]};
    ge       = (trial >= {1'b0, den});
    res.rem  = ge ? SumW'(trial - {1'b0, den}) : trial[SumW-1:0];
    res.bits = {l.bits[QuotW-2:0], ge};
    return res;
  endfunction

  // Returns {saturated, value}.
  function automatic logic [QuotW:0] finish(logic [QuotW-1:0] q, logic num_neg,
                                            logic num_zero, logic a_neg,
                                            logic a_zero, logic ovf);
    logic             neg;
    logic [QuotW-1:0] pos_max, neg_min, lim;
    logic [QuotW:0]   res;
    pos_max = {1'b0, {(QuotW-1){1'b1}}};
    neg_min = {1'b1, {(QuotW-1){1'b0}}};
    neg     = num_neg ^ a_neg;
    lim     = neg ? neg_min : pos_max;
    if (a_zero) begin
      res = {1'b1, num_zero ? {QuotW{1'b0}} : (num_neg ? neg_min : pos_max)};
    end else if (ovf || (q > lim)) begin
      res = {1'b1, lim};
    end else begin
      res = {1'b0, neg ? QuotW'(-q) : q};
    end
    return res;
  endfunction

  logic             adv;
  logic [Steps:0]   vld_q;
  lane_t            x_q [Steps+1];
  lane_t            y_q [Steps+1];
  ctl_t             ctl_q [Steps+1];
  mag_t             den_q [Steps];
  lane_t            x_d, y_d;
  ctl_t             ctl_d;
  logic [QuotW:0]   fin_x, fin_y;

  logic                    out_valid_q;
  logic signed [QuotW-1:0] image_x_q, image_x_d, image_y_q, image_y_d;
  status_e                 status_q, status_d;

  assign adv         = !out_valid_q || !out_stall_i;
  assign job_ready_o = adv;

  // Integer part of |num| >> 12 starts the remainder; quotient >= 2^32 shows here.
  always_comb begin
    x_d.rem      = SumW'(job_i.mag_h[SumW-1:LowW]);
    x_d.bits     = {job_i.mag_h[LowW-1:0], {FracShift{1'b0}}};
    y_d.rem      = SumW'(job_i.mag_v[SumW-1:LowW]);
    y_d.bits     = {job_i.mag_v[LowW-1:0], {FracShift{1'b0}}};
    ctl_d.masked = job_i.masked;
    ctl_d.a_zero = job_i.a_zero;
    ctl_d.a_neg  = job_i.a_neg;
    ctl_d.h_neg  = job_i.h_neg;
    ctl_d.h_zero = job_i.h_zero;
    ctl_d.v_neg  = job_i.v_neg;
    ctl_d.v_zero = job_i.v_zero;
    ctl_d.x_ovf  = (SumW'(job_i.mag_h[SumW-1:LowW]) >= job_i.mag_a);
    ctl_d.y_ovf  = (SumW'(job_i.mag_v[SumW-1:LowW]) >= job_i.mag_a);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Steps-1:0], job_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0]   <= x_d;
      y_q[0]   <= y_d;
      ctl_q[0] <= ctl_d;
      den_q[0] <= job_i.mag_a;
    end
  end

  for (genvar s = 1; s <= Steps; s++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (adv) begin
        x_q[s]   <= div_step(x_q[s-1], den_q[s-1]);
        y_q[s]   <= div_step(y_q[s-1], den_q[s-1]);
        ctl_q[s] <= ctl_q[s-1];
      end
    end
    if (s < Steps) begin : g_den
      always_ff @(posedge clk_i) begin
        if (adv) begin
          den_q[s] <= den_q[s-1];
        end
      end
    end
  end

  always_comb begin
    fin_x = finish(x_q[Steps].bits, ctl_q[Steps].h_neg, ctl_q[Steps].h_zero,
                   ctl_q[Steps].a_neg, ctl_q[Steps].a_zero, ctl_q[Steps].x_ovf);
    fin_y = finish(y_q[Steps].bits, ctl_q[Steps].v_neg, ctl_q[Steps].v_zero,
                   ctl_q[Steps].a_neg, ctl_q[Steps].a_zero, ctl_q[Steps].y_ovf);
    if (ctl_q[Steps].masked) begin
      image_x_d = '0;
      image_y_d = '0;
      status_d  = StatusMasked;
    end else begin
      image_x_d = fin_x[QuotW-1:0];
      image_y_d = fin_y[QuotW-1:0];
      status_d  = (fin_x[QuotW] || fin_y[QuotW]) ? StatusBad : StatusValid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      image_x_q <= image_x_d;
      image_y_q <= image_y_d;
      status_q  <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign image_x_o   = image_x_q;
  assign image_y_o   = image_y_q;
  assign status_o    = status_q;

endmodule

// ===== design/cahv_project_edge_midpoint.sv =====
// CAHV projection of a terrain column-edge midpoint. Each request (two
// northings, eastings, elevations and mask codes) yields one result: image
// x/y in signed Q11.20 and a status (valid, masked, saturated/zero divisor).
// One request per cycle is accepted while in_stall_o is low; the result shows
// on out_valid_o after four front stages (deltas, nine products, sums,
// magnitudes), the queue, the divider input register and a 32-stage restoring
// divider that makes one quotient bit per stage, then an output register. The
// user must write camera registers through the cfg port only while no request
// is in flight; the block does not enforce this. cfg_ready_o is always high.
module cahv_project_edge_midpoint import cahv_pem_pkg::*; #(
  parameter int FifoDepth = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [CoordW-1:0]  north_first_i,
  input  logic signed [CoordW-1:0]  north_second_i,
  input  logic signed [CoordW-1:0]  east_first_i,
  input  logic signed [CoordW-1:0]  east_second_i,
  input  logic signed [CoordW-1:0]  elev_first_i,
  input  logic signed [CoordW-1:0]  elev_second_i,
  input  logic signed [MaskW-1:0]   mask_first_i,
  input  logic signed [MaskW-1:0]   mask_second_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [QuotW-1:0]   image_x_o,
  output logic signed [QuotW-1:0]   image_y_o,
  output logic [1:0]                status_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [VecW-1:0]           cfg_data_i
);

  logic job_valid, job_full, pop_valid, pop_ready;
  job_t job, pop_job;

  assign cfg_ready_o = 1'b1;

  cahv_pem_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .north_first_i  (north_first_i),
    .north_second_i (north_second_i),
    .east_first_i   (east_first_i),
    .east_second_i  (east_second_i),
    .elev_first_i   (elev_first_i),
    .elev_second_i  (elev_second_i),
    .mask_first_i   (mask_first_i),
    .mask_second_i  (mask_second_i),
    .cfg_valid_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .job_valid_o    (job_valid),
    .job_o          (job),
    .job_full_i     (job_full)
  );

  cahv_pem_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_data_i  (job),
    .full_o       (job_full),
    .pop_ready_i  (pop_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_job)
  );

  cahv_pem_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_i       (pop_job),
    .job_ready_o (pop_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .image_x_o   (image_x_o),
    .image_y_o   (image_y_o),
    .status_o    (status_o)
  );

endmodule

// ===== design/cahv_pem_checker.sv =====
`include "assert_macros.svh"

module cahv_pem_checker import cahv_pem_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_i,
  input logic                     out_stall_i,
  input logic signed [QuotW-1:0]  image_x_i,
  input logic signed [QuotW-1:0]  image_y_i,
  input logic [1:0]               status_i
);

  localparam logic [QuotW-1:0] PosMax = {1'b0, {(QuotW-1){1'b1}}};
  localparam logic [QuotW-1:0] NegMin = {1'b1, {(QuotW-1){1'b0}}};

  `CAHV_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i)
  `CAHV_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && out_stall_i, $stable(image_x_i) && $stable(image_y_i) && $stable(status_i))
  `CAHV_ASSERT(a_masked_zero, clk_i, rst_ni, out_valid_i && status_i == StatusMasked |-> image_x_i == '0 && image_y_i == '0)
  // A flagged result always carries at least one bound or a zero-divisor zero.
  `CAHV_ASSERT(a_bad_sat, clk_i, rst_ni, out_valid_i && status_i == StatusBad |-> image_x_i == PosMax || image_x_i == NegMin || image_x_i == '0 || image_y_i == PosMax || image_y_i == NegMin || image_y_i == '0)

endmodule

bind cahv_project_edge_midpoint cahv_pem_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .image_x_i   (image_x_o),
  .image_y_i   (image_y_o),
  .status_i    (status_o)
);
